// File: sv/lcar_pkg.sv
// Package: shared types and constants of the load cell ADC reader.
package lcar_pkg;

	localparam int READ_W     = 24;
	localparam int DIVIDEND_W = 32;
	localparam int HP_W       = 8;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POWER_DOWN  = 2'd2;

	localparam logic [READ_W-1:0] READ_MAX = {READ_W{1'b1}};

	typedef struct packed {
		logic data_pin;
	} tick_t;

	typedef struct packed {
		logic              sck_level;
		logic              weight_valid;
		logic [READ_W-1:0] weight;
		logic [READ_W-1:0] raw_reading;
		logic              tare_captured;
	} result_t;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [READ_W-1:0]     divisor;
	} div_req_t;

	typedef struct packed {
		logic                  done;
		logic [DIVIDEND_W-1:0] quotient;
	} div_rsp_t;

endpackage

// File: sv/lcar_stream_if.sv
// Interface: valid/ready stream channel with a typed payload.
interface lcar_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: sv/lcar_div.sv
// Module: restoring divider, one quotient bit per cycle.
module lcar_div import lcar_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	localparam int CNT_W = $clog2(DIVIDEND_W);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(DIVIDEND_W - 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [READ_W-1:0]     rem_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [READ_W-1:0]     dsr_q;
	logic [READ_W:0]       shifted;
	logic [READ_W:0]       trial;
	logic                  ge;

	assign shifted = {rem_q, quo_q[DIVIDEND_W-1]};
	assign trial   = shifted - {1'b0, dsr_q};
	assign ge      = shifted >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? trial[READ_W-1:0] : shifted[READ_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;
endmodule

// File: sv/load_cell_adc_reader.sv
// Top level: tick-driven serial load cell converter reader with tare and scaling.
// Each tick's result is registered in the output register on its transfer.
// A completed reading with tare captured, raw above tare and nonzero scale runs the
// divider; sample ready stays low until the divider's quotient is registered as weight.
// Throughput: one tick per cycle otherwise, limited by the output register.
// Reset (arst_n low) clears sequencer, tare, last reading and config to defaults.
module load_cell_adc_reader import lcar_pkg::*; #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [READ_W-1:0]    cfg_data,
	lcar_stream_if.sink          sample,
	lcar_stream_if.source        result
);
	localparam int BC_W = $clog2(SAMPLE_BITS + 1);

	localparam logic [2:0] PH_WAIT  = 3'd0;
	localparam logic [2:0] PH_HIGH  = 3'd1;
	localparam logic [2:0] PH_LOW   = 3'd2;
	localparam logic [2:0] PH_XHIGH = 3'd3;
	localparam logic [2:0] PH_XLOW  = 3'd4;

	logic [HP_W-1:0]        hp_q;
	logic [READ_W-1:0]      scale_q;
	logic                   pd_q;
	logic [2:0]             phase_q;
	logic [BC_W-1:0]        bit_cnt_q;
	logic [HP_W-1:0]        tick_q;
	logic [SAMPLE_BITS-1:0] shift_q;
	logic [READ_W-1:0]      tare_q;
	logic                   tare_valid_q;
	logic [READ_W-1:0]      last_raw_q;
	logic                   out_valid_q;
	logic                   wait_div_q;
	result_t                out_q;

	logic [2:0]             nxt_phase;
	logic [BC_W-1:0]        nxt_bc;
	logic [HP_W-1:0]        nxt_tick;
	logic [SAMPLE_BITS-1:0] nxt_shift;
	logic [READ_W-1:0]      nxt_tare;
	logic                   nxt_tv;
	logic [READ_W-1:0]      nxt_raw;
	result_t                res;
	logic                   div_go;

	logic                   in_xfer;
	logic [HP_W-1:0]        hp_eff;
	logic [HP_W:0]          tick_inc;
	logic                   tick_hit;
	logic [BC_W-1:0]        bc_inc;
	logic [SAMPLE_BITS-1:0] flip_w;
	logic [READ_W-1:0]      raw_w;
	logic [READ_W-1:0]      diff_w;
	div_req_t               div_req;
	div_rsp_t               div_rsp;

	assign in_xfer      = sample.valid && sample.ready;
	assign sample.ready = !wait_div_q && (!out_valid_q || result.ready);
	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	assign hp_eff   = (hp_q == '0) ? HP_W'(1) : hp_q;
	assign tick_inc = {1'b0, tick_q} + (HP_W + 1)'(1);
	assign tick_hit = tick_inc >= {1'b0, hp_eff};
	assign bc_inc   = bit_cnt_q + BC_W'(1);
	assign flip_w   = shift_q ^ (SAMPLE_BITS'(1) << (SAMPLE_BITS - 1));
	assign diff_w   = raw_w - tare_q;

	generate
		if (SAMPLE_BITS >= READ_W) begin : g_align_down
			assign raw_w = flip_w[SAMPLE_BITS-1 -: READ_W];
		end else begin : g_align_up
			assign raw_w = {flip_w, {(READ_W - SAMPLE_BITS){1'b0}}};
		end
	endgenerate

	always_comb begin
		nxt_phase = phase_q;
		nxt_bc    = bit_cnt_q;
		nxt_tick  = tick_q;
		nxt_shift = shift_q;
		nxt_tare  = tare_q;
		nxt_tv    = tare_valid_q;
		nxt_raw   = last_raw_q;
		div_go    = 1'b0;
		res       = '0;
		if (pd_q) begin
			nxt_phase     = PH_WAIT;
			nxt_bc        = '0;
			nxt_tick      = '0;
			nxt_shift     = '0;
			res.sck_level = 1'b1;
		end else begin
			unique case (phase_q) inside
				PH_HIGH, PH_XHIGH: begin
					res.sck_level = 1'b1;
					nxt_tick      = tick_inc[HP_W-1:0];
					if (tick_hit) begin
						nxt_tick  = '0;
						nxt_phase = (phase_q == PH_HIGH) ? PH_LOW : PH_XLOW;
					end
				end
				PH_LOW: begin
					nxt_tick = tick_inc[HP_W-1:0];
					if (tick_hit) begin
						nxt_tick  = '0;
						nxt_shift = {shift_q[SAMPLE_BITS-2:0], sample.data.data_pin};
						nxt_bc    = bc_inc;
						nxt_phase = (bc_inc >= BC_W'(SAMPLE_BITS)) ? PH_XHIGH : PH_HIGH;
					end
				end
				PH_XLOW: begin
					nxt_tick = tick_inc[HP_W-1:0];
					if (tick_hit) begin
						nxt_raw = raw_w;
						if (!tare_valid_q) begin
							nxt_tare = raw_w;
							nxt_tv   = 1'b1;
						end else begin
							res.weight_valid = 1'b1;
							if (raw_w > tare_q) begin
								if (scale_q == '0) begin
									res.weight = READ_MAX;
								end else begin
									div_go = 1'b1;
								end
							end
						end
						nxt_phase = PH_WAIT;
						nxt_bc    = '0;
						nxt_tick  = '0;
						nxt_shift = '0;
					end
				end
				default: begin
					nxt_phase = PH_WAIT;
					if (!sample.data.data_pin) begin
						nxt_phase = PH_HIGH;
						nxt_bc    = '0;
						nxt_tick  = '0;
						nxt_shift = '0;
					end
				end
			endcase
		end
		res.raw_reading   = nxt_raw;
		res.tare_captured = nxt_tv;
	end

	assign div_req.start    = in_xfer && div_go;
	assign div_req.dividend = {diff_w, 8'd0};
	assign div_req.divisor  = scale_q;

	lcar_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_q         <= HP_W'(1);
			scale_q      <= READ_W'(256);
			pd_q         <= 1'b0;
			phase_q      <= PH_WAIT;
			bit_cnt_q    <= '0;
			tick_q       <= '0;
			shift_q      <= '0;
			tare_q       <= '0;
			tare_valid_q <= 1'b0;
			last_raw_q   <= '0;
			out_valid_q  <= 1'b0;
			wait_div_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_HALF_PERIOD: hp_q    <= cfg_data[HP_W-1:0];
					CFG_SCALE:       scale_q <= cfg_data;
					CFG_POWER_DOWN:  pd_q    <= cfg_data[0];
					default: ;
				endcase
			end
			if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (in_xfer) begin
				phase_q      <= nxt_phase;
				bit_cnt_q    <= nxt_bc;
				tick_q       <= nxt_tick;
				shift_q      <= nxt_shift;
				tare_q       <= nxt_tare;
				tare_valid_q <= nxt_tv;
				last_raw_q   <= nxt_raw;
				out_valid_q  <= !div_go;
				wait_div_q   <= div_go;
			end
			if (div_rsp.done) begin
				out_valid_q <= 1'b1;
				wait_div_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			out_q <= res;
		end else if (div_rsp.done) begin
			out_q.weight <= (div_rsp.quotient[DIVIDEND_W-1:READ_W] != '0) ? READ_MAX :
				div_rsp.quotient[READ_W-1:0];
		end
	end

	a_div_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> wait_div_q)
		else $error("divider finished with no pending reading");

	a_zero_when_no_weight: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.weight_valid) |-> (out_q.weight == '0))
		else $error("weight nonzero without weight_valid");

	a_tare_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(tare_valid_q))
		else $error("tare lost");

	a_pd_aborts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && pd_q) |=> (phase_q == PH_WAIT))
		else $error("read continued during power down");
endmodule
